// ===== sv/arqs_pkg.sv =====
// ----------------------------------------------------------------------------
// ARQ sender package
// Shared types, codes and default sizes of the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
`default_nettype none

package arqs_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int SEQ_BITS_DEF = 16;
  localparam int MAX_WIN      = 16;

  localparam logic       MODE_RST = 1'b0;
  localparam logic [4:0] WIN_RST  = 5'd4;
  localparam logic [15:0] TMO_RST = 16'd3;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_SENT    = 3'd0,
    EV_RETX    = 3'd1,
    EV_FULL    = 3'd2,
    EV_ACK_OK  = 3'd3,
    EV_ACK_IGN = 3'd4,
    EV_DONE    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_WIN  = 2'd1,
    REG_TMO  = 2'd2,
    REG_RSVD = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND,
    S_MOD,
    S_ACK,
    S_SLIDE,
    S_ACKRES,
    S_DONE,
    S_TSR,
    S_TGBN
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] ack_num;
    logic        final_packet;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] seq_num;
    logic [3:0]  slot;
    logic [15:0] window_base;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        arq_mode;
    logic [4:0]  win_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/sliding_window_arq_sender.sv =====
// ----------------------------------------------------------------------------
// Sliding-window ARQ sender
// Go-Back-N / Selective Repeat sender control with an APB register port.
// ----------------------------------------------------------------------------
// One command item is taken at a time and the input stalls until its work is
// done. A send emits one sent or full result. An ack gets its slot from a
// two-stage reciprocal-multiply reduction unit; in Selective Repeat a slide
// check then releases the acked slots at the window base, and an ack that
// completes the transfer also emits an all-done item. A tick walks the
// outstanding packets one slot per cycle in Selective Repeat while a staged
// retransmit is not held. In Go-Back-N a tick that fires nothing emits no
// result, and a timeout emits one retransmit per cycle, while the output is
// not held, for every outstanding packet. Results wait in an output register,
// and the sequencer holds while that register is full and the receiver stalls.
`default_nettype none

module sliding_window_arq_sender import arqs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        mode_r;
  logic [4:0]  win_r;
  logic [15:0] tmo_r;
  cfg_t        cfg;
  reg_idx_t    ridx;
  logic        wr_en;

  logic        in_ready;
  logic        res_valid, res_ready;
  out_item_t   res;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RST;
      win_r  <= WIN_RST;
      tmo_r  <= TMO_RST;
    end else if (wr_en) begin
      unique case (ridx)
        REG_MODE: mode_r <= pwdata[0];
        REG_WIN:  win_r  <= pwdata[4:0];
        REG_TMO:  tmo_r  <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MODE: prdata = {31'd0, mode_r};
      REG_WIN:  prdata = {27'd0, win_r};
      REG_TMO:  prdata = {16'd0, tmo_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg = '{arq_mode: mode_r, win_limit: win_r, timeout_ticks: tmo_r};

  arqs_core #(.SLOTS(SLOTS), .SEQ_BITS(SEQ_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign in_stall  = !in_ready;
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/arqs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Slot reduction unit
// Reduces a sequence number modulo the slot count by a reciprocal multiply,
// in a pipelined product stage and remainder stage.
// ----------------------------------------------------------------------------
`default_nettype none

module arqs_mod_unit import arqs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [SEQ_BITS-1:0]       value,
  output logic                           done,
  output logic [$clog2(SLOTS)-1:0]       result
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int SHIFT     = SEQ_BITS + SLOT_BITS;
  localparam int MUL_W     = SEQ_BITS + 1;
  localparam int PROD_W    = SEQ_BITS + MUL_W;
  // Rounding the reciprocal up with this shift makes the truncated product
  // the exact quotient for every value of SEQ_BITS bits.
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  logic                 stg_r, stg_nxt;
  logic                 done_r, done_nxt;
  logic [SEQ_BITS-1:0]  val_r, val_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [SLOT_BITS-1:0] res_r, res_nxt;
  logic [PROD_W-1:0]    quo_full;
  logic [SEQ_BITS-1:0]  quo, quo_mul, rem;

  always_comb begin
    stg_nxt  = start;
    done_nxt = stg_r;
    val_nxt  = start ? value : val_r;
    prod_nxt = start ? PROD_W'(value) * PROD_W'(RECIP) : prod_r;
    quo_full = prod_r >> SHIFT;
    quo      = quo_full[SEQ_BITS-1:0];
    quo_mul  = quo * SEQ_BITS'(SLOTS);
    rem      = val_r - quo_mul;
    res_nxt  = stg_r ? rem[SLOT_BITS-1:0] : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= stg_nxt;
      done_r <= done_nxt;
    end
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// ===== sv/arqs_core.sv =====
// ----------------------------------------------------------------------------
// ARQ sender core
// Window state, per-slot flags and timers, and the sequencer that walks them.
// ----------------------------------------------------------------------------
`default_nettype none

module arqs_core import arqs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  output logic           in_ready,
  output logic           res_valid,
  output out_item_t      res,
  input  wire logic      res_ready
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int WCAP      = (MAX_WIN < SLOTS) ? MAX_WIN : SLOTS;
  localparam int CW        = $clog2(WCAP + 1);

  typedef logic [SEQ_BITS-1:0]  seq_t;
  typedef logic [SLOT_BITS-1:0] sidx_t;

  state_t state_r, state_nxt;

  seq_t        base_r, base_nxt, next_r, next_nxt, final_r, final_nxt;
  sidx_t       base_slot_r, base_slot_nxt, next_slot_r, next_slot_nxt;
  sidx_t       final_slot_r, final_slot_nxt;
  logic        final_known_r, final_known_nxt, finished_r, finished_nxt;
  logic [SLOTS-1:0] acked_r, acked_nxt, trun_r, trun_nxt;
  logic [15:0] telap_r [SLOTS];
  logic [15:0] telap_nxt [SLOTS];

  seq_t        ack_r, ack_nxt, ws_r, ws_nxt, pend_seq_r, pend_seq_nxt;
  sidx_t       ack_slot_r, ack_slot_nxt, wslot_r, wslot_nxt;
  sidx_t       pend_slot_r, pend_slot_nxt;
  logic        fin_r, fin_nxt, pend_r, pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic        accept;
  logic        mod_done;
  sidx_t       mod_slot;
  seq_t        in_ack, outstanding, ack_off, ack_inc;
  logic        full, ack_bad, all_out, sr_fires, sr_run, tsr_go;
  int unsigned eff_win;

  function automatic sidx_t step_slot(input seq_t s_new, input sidx_t sl);
    sidx_t r;
    if (s_new == '0) r = '0;
    else if (sl == sidx_t'(SLOTS - 1)) r = '0;
    else r = sl + 1'b1;
    return r;
  endfunction

  function automatic out_item_t mk(input event_t ev, input seq_t s, input sidx_t sl,
                                   input seq_t b, input logic last);
    out_item_t   o;
    logic [31:0] s32, b32, sl32;
    s32  = 32'(s);
    b32  = 32'(b);
    sl32 = 32'(sl);
    o.event_res   = ev;
    o.seq_num     = s32[15:0];
    o.slot        = sl32[3:0];
    o.window_base = b32[15:0];
    o.last_of_run = last;
    return o;
  endfunction

  arqs_mod_unit #(.SLOTS(SLOTS), .SEQ_BITS(SEQ_BITS)) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && (in_item.cmd == CMD_ACK)),
    .value  (in_ack),
    .done   (mod_done),
    .result (mod_slot)
  );

  assign accept = in_valid && in_ready;
  assign in_ack = seq_t'(in_item.ack_num);

  always_comb begin
    if (cfg.win_limit == 5'd0) eff_win = 1;
    else if (int'(cfg.win_limit) > WCAP) eff_win = WCAP;
    else eff_win = int'(cfg.win_limit);
  end

  assign outstanding = next_r - base_r;
  assign ack_off     = ack_r - base_r;
  assign ack_inc     = ack_r + 1'b1;
  assign full        = final_known_r || (32'(outstanding) >= 32'(eff_win));
  assign ack_bad     = finished_r || (ack_off >= outstanding);
  assign all_out     = final_known_r && (base_r == next_r);
  // A slot whose timer runs and is not yet acked counts this tick.
  assign sr_run      = trun_r[wslot_r] && !acked_r[wslot_r];
  assign sr_fires    = sr_run && (telap_r[wslot_r] >= cfg.timeout_ticks);
  // A new firing while one is still staged must first push the staged item.
  assign tsr_go      = !(sr_fires && pend_r) || res_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.cmd)
            CMD_SEND: state_nxt = S_SEND;
            CMD_ACK:  state_nxt = S_MOD;
            CMD_TICK: begin
              if (finished_r) state_nxt = S_IDLE;
              else if (cfg.arq_mode) state_nxt = S_TSR;
              else if (trun_r[0] && (outstanding != '0) &&
                       (telap_r[0] >= cfg.timeout_ticks)) state_nxt = S_TGBN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEND:   if (res_ready) state_nxt = S_IDLE;
      S_MOD:    if (mod_done) state_nxt = S_ACK;
      S_ACK: begin
        if (ack_bad) begin
          if (res_ready) state_nxt = S_IDLE;
        end else if (cfg.arq_mode) state_nxt = S_SLIDE;
        else state_nxt = S_ACKRES;
      end
      S_SLIDE:  if (cnt_r == '0 || !acked_r[base_slot_r]) state_nxt = S_ACKRES;
      S_ACKRES: if (res_ready) state_nxt = all_out ? S_DONE : S_IDLE;
      S_DONE:   if (res_ready) state_nxt = S_IDLE;
      S_TSR: begin
        if (cnt_r == '0 && (!pend_r || res_ready)) state_nxt = S_IDLE;
      end
      S_TGBN:   if (res_ready && cnt_r == CW'(1)) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = mk(EV_SENT, next_r, next_slot_r, base_r, 1'b1);
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SEND: begin
        res_valid = 1'b1;
        res = mk(full ? EV_FULL : EV_SENT, next_r, next_slot_r, base_r, 1'b1);
      end
      S_ACK: begin
        res_valid = ack_bad;
        res = mk(EV_ACK_IGN, ack_r, ack_slot_r, base_r, 1'b1);
      end
      S_ACKRES: begin
        res_valid = 1'b1;
        res = mk(EV_ACK_OK, ack_r, ack_slot_r, base_r, !all_out);
      end
      S_DONE: begin
        res_valid = 1'b1;
        res = mk(EV_DONE, final_r, final_slot_r, base_r, 1'b1);
      end
      S_TSR: begin
        res_valid = pend_r && ((cnt_r == '0) || sr_fires);
        res = mk(EV_RETX, pend_seq_r, pend_slot_r, base_r, cnt_r == '0);
      end
      S_TGBN: begin
        res_valid = 1'b1;
        res = mk(EV_RETX, ws_r, wslot_r, base_r, cnt_r == CW'(1));
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    base_nxt        = base_r;
    next_nxt        = next_r;
    final_nxt       = final_r;
    base_slot_nxt   = base_slot_r;
    next_slot_nxt   = next_slot_r;
    final_slot_nxt  = final_slot_r;
    final_known_nxt = final_known_r;
    finished_nxt    = finished_r;
    acked_nxt       = acked_r;
    trun_nxt        = trun_r;
    telap_nxt       = telap_r;
    ack_nxt         = ack_r;
    ack_slot_nxt    = ack_slot_r;
    fin_nxt         = fin_r;
    ws_nxt          = ws_r;
    wslot_nxt       = wslot_r;
    cnt_nxt         = cnt_r;
    pend_nxt        = pend_r;
    pend_seq_nxt    = pend_seq_r;
    pend_slot_nxt   = pend_slot_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ack_nxt   = in_ack;
          fin_nxt   = in_item.final_packet;
          ws_nxt    = base_r;
          wslot_nxt = base_slot_r;
          cnt_nxt   = CW'(outstanding);
          pend_nxt  = 1'b0;
          if (in_item.cmd == CMD_TICK && !finished_r && !cfg.arq_mode && trun_r[0]) begin
            // Single Go-Back-N timer lives in slot zero.
            if (outstanding == '0) begin
              trun_nxt[0]  = 1'b0;
              telap_nxt[0] = '0;
            end else if (telap_r[0] >= cfg.timeout_ticks) begin
              telap_nxt[0] = '0;
            end else begin
              telap_nxt[0] = telap_r[0] + 1'b1;
            end
          end
        end
      end
      S_SEND: begin
        if (res_ready && !full) begin
          acked_nxt[next_slot_r] = 1'b0;
          if (cfg.arq_mode) begin
            trun_nxt[next_slot_r]  = 1'b1;
            telap_nxt[next_slot_r] = '0;
          end else if (base_r == next_r) begin
            trun_nxt[0]  = 1'b1;
            telap_nxt[0] = '0;
          end
          next_nxt      = next_r + 1'b1;
          next_slot_nxt = step_slot(next_r + 1'b1, next_slot_r);
          if (fin_r) begin
            final_nxt       = next_r;
            final_slot_nxt  = next_slot_r;
            final_known_nxt = 1'b1;
          end
        end
      end
      S_MOD: begin
        if (mod_done) ack_slot_nxt = mod_slot;
      end
      S_ACK: begin
        if (!ack_bad) begin
          if (cfg.arq_mode) begin
            acked_nxt[ack_slot_r] = 1'b1;
            trun_nxt[ack_slot_r]  = 1'b0;
            telap_nxt[ack_slot_r] = '0;
            cnt_nxt               = CW'(outstanding);
          end else begin
            base_nxt      = ack_inc;
            base_slot_nxt = step_slot(ack_inc, ack_slot_r);
            telap_nxt[0]  = '0;
            trun_nxt[0]   = (ack_inc != next_r);
          end
        end
      end
      S_SLIDE: begin
        if (cnt_r != '0 && acked_r[base_slot_r]) begin
          acked_nxt[base_slot_r] = 1'b0;
          base_nxt      = base_r + 1'b1;
          base_slot_nxt = step_slot(base_r + 1'b1, base_slot_r);
          cnt_nxt       = cnt_r - 1'b1;
        end
      end
      S_ACKRES: begin
        if (res_ready && all_out) begin
          finished_nxt = 1'b1;
          trun_nxt     = '0;
          for (int i = 0; i < SLOTS; i++) telap_nxt[i] = '0;
        end
      end
      S_TSR: begin
        if (cnt_r == '0) begin
          if (res_ready) pend_nxt = 1'b0;
        end else if (tsr_go) begin
          if (sr_run) begin
            if (sr_fires) telap_nxt[wslot_r] = '0;
            else telap_nxt[wslot_r] = telap_r[wslot_r] + 1'b1;
          end
          if (sr_fires) begin
            pend_nxt      = 1'b1;
            pend_seq_nxt  = ws_r;
            pend_slot_nxt = wslot_r;
          end
          ws_nxt    = ws_r + 1'b1;
          wslot_nxt = step_slot(ws_r + 1'b1, wslot_r);
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      S_TGBN: begin
        if (res_ready) begin
          ws_nxt    = ws_r + 1'b1;
          wslot_nxt = step_slot(ws_r + 1'b1, wslot_r);
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      base_r        <= '0;
      next_r        <= '0;
      final_r       <= '0;
      base_slot_r   <= '0;
      next_slot_r   <= '0;
      final_slot_r  <= '0;
      final_known_r <= 1'b0;
      finished_r    <= 1'b0;
      acked_r       <= '0;
      trun_r        <= '0;
      pend_r        <= 1'b0;
      for (int i = 0; i < SLOTS; i++) telap_r[i] <= '0;
    end else begin
      state_r       <= state_nxt;
      base_r        <= base_nxt;
      next_r        <= next_nxt;
      final_r       <= final_nxt;
      base_slot_r   <= base_slot_nxt;
      next_slot_r   <= next_slot_nxt;
      final_slot_r  <= final_slot_nxt;
      final_known_r <= final_known_nxt;
      finished_r    <= finished_nxt;
      acked_r       <= acked_nxt;
      trun_r        <= trun_nxt;
      pend_r        <= pend_nxt;
      telap_r       <= telap_nxt;
    end
    ack_r       <= ack_nxt;
    ack_slot_r  <= ack_slot_nxt;
    fin_r       <= fin_nxt;
    ws_r        <= ws_nxt;
    wslot_r     <= wslot_nxt;
    cnt_r       <= cnt_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_slot_r <= pend_slot_nxt;
  end

endmodule

`default_nettype wire

// ===== dv/tb_sliding_window_arq_sender.sv =====
// ----------------------------------------------------------------------------
// Sliding-window ARQ sender testbench
// Drives send, ack, tick and unused command items in Go-Back-N and Selective
// Repeat modes, predicts every result from a behavioral copy of the sender state
// and checks each whole result, with random idling on both sides in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sliding_window_arq_sender;
  import arqs_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sliding_window_arq_sender dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Sender state as predicted.
  logic        mode_sr;
  logic [4:0]  win_reg;
  logic [15:0] tmo_reg;
  logic [15:0] base_q;
  logic [15:0] next_q;
  logic [15:0] final_q;
  logic        final_seen;
  logic        done_q;
  logic [NSLOT-1:0] acked_q;
  logic [NSLOT-1:0] run_q;
  logic [15:0] elapsed_q [NSLOT];

  out_item_t   expected_q [$];
  int          errors;
  int          cycles;
  bit          idle_enable;
  bit          out_idle_enable;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stall and result checking.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors <= errors + 1;
        end else if (out_data !== expected_q[0]) begin
          $display("%0t: expected %h actual %h", $time, expected_q[0], out_data);
          errors <= errors + 1;
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      out_stall <= out_idle_enable && ($urandom_range(99) < 21);
    end
  end

  function automatic logic [4:0] eff_win();
    logic [4:0] w;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > 16) w = 16;
    return w;
  endfunction

  function automatic void push_result(logic [2:0] ev, logic [15:0] s);
    out_item_t r;
    r.event_res   = ev;
    r.seq_num     = s;
    r.slot        = s[3:0];
    r.window_base = base_q;
    r.last_of_run = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic bit tick_slot(int t);
    if (elapsed_q[t] >= tmo_reg) begin
      elapsed_q[t] = 0;
      return 1;
    end
    elapsed_q[t] = elapsed_q[t] + 16'd1;
    return 0;
  endfunction

  // Updates the predicted state for one item and queues its results.
  function automatic void predict_arq(in_item_t it);
    int n;
    int cnt;
    logic [15:0] outst;
    logic [15:0] off;
    logic [15:0] s;
    out_item_t lastr;
    n = expected_q.size();
    outst = next_q - base_q;
    if (it.cmd == CMD_SEND) begin
      s = next_q;
      if (final_seen || outst >= eff_win()) begin
        push_result(EV_FULL, s);
      end else begin
        acked_q[s[3:0]] = 1'b0;
        if (mode_sr) begin
          run_q[s[3:0]] = 1'b1;
          elapsed_q[s[3:0]] = 0;
        end else if (base_q == next_q) begin
          run_q[0] = 1'b1;
          elapsed_q[0] = 0;
        end
        next_q = next_q + 16'd1;
        if (it.final_packet) begin
          final_q = s;
          final_seen = 1'b1;
        end
        push_result(EV_SENT, s);
      end
    end else if (it.cmd == CMD_ACK) begin
      off = it.ack_num - base_q;
      if (done_q || off >= outst) begin
        push_result(EV_ACK_IGN, it.ack_num);
      end else begin
        if (mode_sr) begin
          acked_q[it.ack_num[3:0]] = 1'b1;
          run_q[it.ack_num[3:0]] = 1'b0;
          elapsed_q[it.ack_num[3:0]] = 0;
          for (int i = 0; i < outst; i++) begin
            if (!acked_q[base_q[3:0]]) break;
            acked_q[base_q[3:0]] = 1'b0;
            base_q = base_q + 16'd1;
          end
        end else begin
          base_q = it.ack_num + 16'd1;
          elapsed_q[0] = 0;
          run_q[0] = (base_q != next_q);
        end
        push_result(EV_ACK_OK, it.ack_num);
        if (final_seen && base_q == next_q) begin
          done_q = 1'b1;
          run_q = '0;
          for (int i = 0; i < NSLOT; i++) elapsed_q[i] = 0;
          push_result(EV_DONE, final_q);
        end
      end
    end else if (it.cmd == CMD_TICK && !done_q) begin
      cnt = outst;
      if (mode_sr) begin
        for (int i = 0; i < cnt; i++) begin
          s = base_q + i[15:0];
          if (run_q[s[3:0]] && !acked_q[s[3:0]] && tick_slot(s[3:0]))
            push_result(EV_RETX, s);
        end
      end else if (run_q[0]) begin
        if (cnt == 0) begin
          run_q[0] = 1'b0;
          elapsed_q[0] = 0;
        end else if (tick_slot(0)) begin
          for (int i = 0; i < cnt; i++) push_result(EV_RETX, base_q + i[15:0]);
        end
      end
    end
    if (expected_q.size() > n) begin
      lastr = expected_q.pop_back();
      lastr.last_of_run = 1'b1;
      expected_q.push_back(lastr);
    end
  endfunction

  task automatic send_item(logic [1:0] c, logic [15:0] a, logic f);
    in_item_t it;
    it.cmd = c;
    it.ack_num = a;
    it.final_packet = f;
    while (idle_enable && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_arq(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE: mode_sr = val[0];
      REG_WIN:  win_reg = val[4:0];
      REG_TMO:  tmo_reg = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only once all queued results have drained, and no fresh
  // transfer state is set up: the sender simply carries on from where it stands.
  task automatic setup_mode(logic sr, logic [4:0] w, logic [15:0] t);
    wait_drained();
    write_reg(REG_MODE, {31'd0, sr});
    write_reg(REG_WIN, {27'd0, w});
    write_reg(REG_TMO, {16'd0, t});
  endtask

  task automatic test_directed_gbn();
    setup_mode(1'b0, 5'd0, 16'd0);
    send_item(CMD_SEND, 16'h0, 1'b0);
    send_item(CMD_SEND, 16'h0, 1'b0);
    send_item(CMD_TICK, 16'h0, 1'b0);
    send_item(CMD_NONE, 16'hffff, 1'b1);
    send_item(CMD_ACK, 16'hffff, 1'b0);
    send_item(CMD_ACK, 16'h0, 1'b0);
    send_item(CMD_TICK, 16'h0, 1'b0);
    setup_mode(1'b0, 5'd31, 16'd1);
    for (int i = 0; i < 17; i++) send_item(CMD_SEND, 16'h0, 1'b0);
    repeat (3) send_item(CMD_TICK, 16'h0, 1'b0);
    send_item(CMD_ACK, next_q - 16'd2, 1'b0);
    send_item(CMD_TICK, 16'h0, 1'b0);
    send_item(CMD_TICK, 16'h0, 1'b0);
  endtask

  task automatic test_directed_sr();
    setup_mode(1'b1, 5'd16, 16'hffff);
    send_item(CMD_ACK, next_q - 16'd1, 1'b0);
    send_item(CMD_SEND, 16'h0, 1'b0);
    send_item(CMD_SEND, 16'h0, 1'b1);
    send_item(CMD_SEND, 16'h0, 1'b0);
    send_item(CMD_ACK, next_q - 16'd1, 1'b0);
    send_item(CMD_ACK, next_q - 16'd1, 1'b0);
    send_item(CMD_ACK, base_q, 1'b0);
    send_item(CMD_ACK, base_q, 1'b0);
    send_item(CMD_TICK, 16'h0, 1'b0);
  endtask

  // Random transfers: mostly sends, in-window acks and ticks, with some
  // stray acks and unused commands. A send is marked final at random.
  task automatic test_random_traffic();
    int k;
    int total;
    logic [15:0] a;
    logic [15:0] outst;
    total = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: setup_mode(1'b0, 5'd1, 16'd1);
        1: setup_mode(1'b1, 5'd16, 16'd0);
        2: setup_mode(1'b0, 5'd16, 16'd2);
        3: setup_mode(1'b1, 5'd3, 16'd2);
        default: setup_mode(1'($urandom_range(1)), 5'($urandom_range(31)),
                            16'($urandom_range(4)));
      endcase
      idle_enable = (ph != 2);
      out_idle_enable = (ph != 2);
      for (int i = 0; i < 28; i++) begin
        k = $urandom_range(99);
        outst = next_q - base_q;
        if (k < 35) begin
          send_item(CMD_SEND, 16'($urandom), ($urandom_range(40) == 0));
        end else if (k < 60) begin
          a = (outst != 0) ? base_q + 16'($urandom_range(outst - 1)) : base_q;
          send_item(CMD_ACK, a, 1'($urandom));
        end else if (k < 85) begin
          send_item(CMD_TICK, 16'($urandom), 1'($urandom));
        end else if (k < 95) begin
          send_item(CMD_ACK, 16'($urandom), 1'($urandom));
        end else begin
          send_item(CMD_NONE, 16'($urandom), 1'($urandom));
        end
      end
    end
    idle_enable = 1;
    out_idle_enable = 1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    idle_enable = 1;
    out_idle_enable = 1;
    mode_sr = MODE_RST;
    win_reg = WIN_RST;
    tmo_reg = TMO_RST;
    base_q = 0;
    next_q = 0;
    final_q = 0;
    final_seen = 0;
    done_q = 0;
    acked_q = '0;
    run_q = '0;
    for (int i = 0; i < NSLOT; i++) elapsed_q[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_gbn();
    test_directed_sr();
    test_random_traffic();
    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
